>>> rtl/core/i2cmbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2cmbe_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned WAIT_W        = 8;
   localparam int unsigned BITCNT_W      = 4;

   localparam logic [BITCNT_W-1:0] BIT_COUNT_LAST = BITCNT_W'(BITS_PER_BYTE);

   // Command codes; six and seven are not commands.
   localparam logic [2:0] CMD_START     = 3'd0;
   localparam logic [2:0] CMD_STOP      = 3'd1;
   localparam logic [2:0] CMD_WRITE     = 3'd2;
   localparam logic [2:0] CMD_READ      = 3'd3;
   localparam logic [2:0] CMD_SEND_ACK  = 3'd4;
   localparam logic [2:0] CMD_RECV_ACK  = 3'd5;

   // Configuration register indexes.
   localparam logic CSR_LONG_WAIT  = 1'b0;
   localparam logic CSR_SHORT_WAIT = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_ST_A    = 4'd1,
      PH_ST_B    = 4'd2,
      PH_SP_A    = 4'd3,
      PH_SP_B    = 4'd4,
      PH_SA_LOW  = 4'd5,
      PH_SA_DATA = 4'd6,
      PH_SA_HIGH = 4'd7,
      PH_RA_LOW  = 4'd8,
      PH_RA_HIGH = 4'd9,
      PH_WB_LOW  = 4'd10,
      PH_WB_DATA = 4'd11,
      PH_WB_HIGH = 4'd12,
      PH_RB_LOW  = 4'd13,
      PH_RB_HIGH = 4'd14
   } phase_type;

   typedef struct packed {
      logic [WAIT_W-1:0] long_wait;
      logic [WAIT_W-1:0] short_wait;
   } cfg_type;

   typedef struct packed {
      logic       ack_seen;
      logic [7:0] read_data;
      logic       done_res;
      logic       busy_res;
      logic       sda_release;
      logic       scl_level;
   } result_type;

   // A wait of zero ticks is stretched to one.
   function automatic logic [WAIT_W-1:0] load_wait(input logic [WAIT_W-1:0] w);
      return (w == '0) ? WAIT_W'(1) : w;
   endfunction

endpackage

>>> rtl/core/i2cmbe_seq.sv
// Line sequencer: phase register, wait and bit counters, shift and result state.
// Depends on i2cmbe_pkg.
`timescale 1ns / 1ps

module i2cmbe_seq
   import i2cmbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       cmd_valid,
   input  logic [2:0] command,
   input  logic [7:0] write_byte,
   input  logic       ack_value,
   input  logic       sda_line,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type             phase_ff, phase_in;
   logic [WAIT_W-1:0]     wait_ff, wait_in, wait_dec;
   logic [BITCNT_W-1:0]   bitcnt_ff, bitcnt_in;
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            read_ff, read_in;
   logic                  ack_ff, ack_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  done;
   logic                  cmd_ok;

   assign cmd_ok   = cmd_valid && (command <= CMD_RECV_ACK);
   assign wait_dec = (wait_ff != '0) ? wait_ff - WAIT_W'(1) : wait_ff;

   always_comb begin
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      bitcnt_in = bitcnt_ff;
      shift_in  = shift_ff;
      read_in   = read_ff;
      ack_in    = ack_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      done      = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (cmd_ok) begin
               wait_in = load_wait(cfg.long_wait);
               unique case (command)
                  CMD_START: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     phase_in = PH_ST_A;
                  end
                  CMD_STOP: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b0;
                     phase_in = PH_SP_A;
                  end
                  CMD_WRITE: begin
                     shift_in  = write_byte;
                     bitcnt_in = '0;
                     scl_in    = 1'b0;
                     phase_in  = PH_WB_LOW;
                  end
                  CMD_READ: begin
                     shift_in  = '0;
                     bitcnt_in = '0;
                     scl_in    = 1'b0;
                     sda_in    = 1'b1;
                     phase_in  = PH_RB_LOW;
                  end
                  CMD_SEND_ACK: begin
                     shift_in = {7'd0, ack_value};
                     scl_in   = 1'b0;
                     phase_in = PH_SA_LOW;
                  end
                  default: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                     phase_in = PH_RA_LOW;
                  end
               endcase
            end
         end
         PH_RA_HIGH: begin
            ack_in   = sda_line;
            scl_in   = 1'b0;
            phase_in = PH_IDLE;
            done     = 1'b1;
         end
         PH_RB_HIGH: begin
            shift_in  = {shift_ff[6:0], sda_line};
            bitcnt_in = bitcnt_ff + BITCNT_W'(1);
            scl_in    = 1'b0;
            if (bitcnt_in >= BIT_COUNT_LAST) begin
               read_in  = shift_in;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end else begin
               phase_in = PH_RB_LOW;
               wait_in  = load_wait(cfg.long_wait);
            end
         end
         default: begin
            // Timed phases: count the wait down, then take the next edge.
            wait_in = wait_dec;
            if (wait_dec == '0) begin
               unique case (phase_ff)
                  PH_ST_A: begin
                     sda_in   = 1'b0;
                     phase_in = PH_ST_B;
                     wait_in  = load_wait(cfg.long_wait);
                  end
                  PH_ST_B: begin
                     scl_in   = 1'b0;
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  PH_SP_A: begin
                     sda_in   = 1'b1;
                     phase_in = PH_SP_B;
                     wait_in  = load_wait(cfg.long_wait);
                  end
                  PH_SP_B: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  PH_SA_LOW: begin
                     sda_in   = shift_ff[0];
                     phase_in = PH_SA_DATA;
                     wait_in  = load_wait(cfg.short_wait);
                  end
                  PH_SA_DATA: begin
                     scl_in   = 1'b1;
                     phase_in = PH_SA_HIGH;
                     wait_in  = load_wait(cfg.long_wait);
                  end
                  PH_SA_HIGH: begin
                     scl_in   = 1'b0;
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  PH_RA_LOW: begin
                     scl_in   = 1'b1;
                     phase_in = PH_RA_HIGH;
                  end
                  PH_WB_LOW: begin
                     sda_in   = shift_ff[7];
                     phase_in = PH_WB_DATA;
                     wait_in  = load_wait(cfg.short_wait);
                  end
                  PH_WB_DATA: begin
                     scl_in   = 1'b1;
                     phase_in = PH_WB_HIGH;
                     wait_in  = load_wait(cfg.long_wait);
                  end
                  PH_WB_HIGH: begin
                     shift_in  = {shift_ff[6:0], 1'b0};
                     bitcnt_in = bitcnt_ff + BITCNT_W'(1);
                     scl_in    = 1'b0;
                     if (bitcnt_in >= BIT_COUNT_LAST) begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        phase_in = PH_WB_LOW;
                        wait_in  = load_wait(cfg.long_wait);
                     end
                  end
                  PH_RB_LOW: begin
                     scl_in   = 1'b1;
                     phase_in = PH_RB_HIGH;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         wait_ff   <= '0;
         bitcnt_ff <= '0;
         shift_ff  <= '0;
         read_ff   <= '0;
         ack_ff    <= 1'b0;
         scl_ff    <= 1'b1;
         sda_ff    <= 1'b1;
      end else if (step) begin
         phase_ff  <= phase_in;
         wait_ff   <= wait_in;
         bitcnt_ff <= bitcnt_in;
         shift_ff  <= shift_in;
         read_ff   <= read_in;
         ack_ff    <= ack_in;
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
      end
   end

   assign result.scl_level   = scl_in;
   assign result.sda_release = sda_in;
   assign result.busy_res    = (phase_in != PH_IDLE);
   assign result.done_res    = done;
   assign result.read_data   = read_in;
   assign result.ack_seen    = ack_in;

`ifndef NO_ASSERTIONS
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_IDLE && !cmd_ok) |=> (phase_ff == PH_IDLE))
      else $error("sequencer left idle without a command");

   a_bitcnt_range: assert property (@(posedge clock) disable iff (reset)
      (bitcnt_ff <= BIT_COUNT_LAST))
      else $error("bit counter ran past one byte");

   a_ra_high_entry: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && phase_ff == PH_RA_HIGH && $past(phase_ff) != PH_RA_HIGH)
      |-> ($past(phase_ff) == PH_RA_LOW && scl_ff))
      else $error("ack sample phase entered out of order");
`endif

endmodule

>>> rtl/core/i2cmbe_skid.sv
// Two-entry output buffer: result register plus skid register.
// Depends on i2cmbe_pkg for the result type.
`timescale 1ns / 1ps

module i2cmbe_skid
   import i2cmbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;

   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid && in_ready) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result ahead of the output register");
`endif

endmodule

>>> rtl/core/i2c_master_bit_engine_core.sv
// Top level of the tick-driven I2C master bit engine.
// Depends on i2cmbe_pkg, i2cmbe_seq and i2cmbe_skid.
`timescale 1ns / 1ps

// Usage:
// Each transfer on the req_ channel is one timer tick. A tick may carry a
// command (start, stop, write byte, read byte, send ack, receive ack) which
// is taken only while the engine is idle; otherwise the tick just advances
// the sequence and carries the sampled SDA level. Every accepted tick yields
// exactly one transfer on the rsp_ channel with the SCL level, the SDA
// release flag, busy, a done pulse, the last read byte and the last slave ack.
// An accepted tick's result is registered in the result register, or in the
// skid register while one waits. One tick is accepted every clock cycle while
// req_tready is high; the sequencer's next-state logic does the whole update.
// A result register and a skid register sit on the rsp_ side, so req_tready
// stays high while one result waits; it drops only when both are full, which
// happens when a result waits unaccepted while another tick arrives, and
// rises again as soon as a result is taken.
// Reset (synchronous, active high) returns the engine to idle with SCL and
// SDA released high, empties the output buffer and restores the wait
// registers to five long and one short tick. Write the csr_ registers only
// while the engine is idle.

module i2c_master_bit_engine_core
   import i2cmbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Tick and command input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // write_byte[7:0], ack_value[8], sda_line[9], zero[15:10]
   input  logic [3:0]  req_tuser,  // cmd_valid[0], command[3:1]
   // Per-tick line and status result.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // scl_level[0], sda_release[1], busy_res[2], done_res[3],
                                   // read_data[11:4], ack_seen[12], zero[15:13]
   // Configuration writes: index 0 long wait, index 1 short wait.
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);

   cfg_type    cfg_ff;
   result_type seq_result;
   result_type rsp_result;
   logic       step;

   // Wait lengths in ticks, written through the plain register port.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_wait  <= WAIT_W'(5);
         cfg_ff.short_wait <= WAIT_W'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_LONG_WAIT:  cfg_ff.long_wait  <= csr_wdata;
            CSR_SHORT_WAIT: cfg_ff.short_wait <= csr_wdata;
            default:        cfg_ff            <= cfg_ff;
         endcase
      end
   end

   // The state advances only on a completed input transfer.
   assign step = req_tvalid && req_tready;

   i2cmbe_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cmd_valid  (req_tuser[0]),
      .command    (req_tuser[3:1]),
      .write_byte (req_tdata[7:0]),
      .ack_value  (req_tdata[8]),
      .sda_line   (req_tdata[9]),
      .cfg        (cfg_ff),
      .result     (seq_result)
   );

   i2cmbe_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (seq_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {3'd0,
                       rsp_result.ack_seen,
                       rsp_result.read_data,
                       rsp_result.done_res,
                       rsp_result.busy_res,
                       rsp_result.sda_release,
                       rsp_result.scl_level};

endmodule
